// ===== src/frc_pkg.sv =====
// ----------------------------------------------------------------------------
// frc_pkg
// Types and constants shared by the frame receive checker modules.
// ----------------------------------------------------------------------------
package frc_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned SUM_W   = 64;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CFGIX_W = 1;

	localparam logic [BYTE_W-1:0] OFFSET_CHAR   = 8'h30;
	localparam logic [LEN_W-1:0]  CS_LAST_INDEX = 16'd7;
	localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RESET = 16'd255;

	localparam logic [CFGIX_W-1:0] REG_EXPECTED_COMMAND = 1'd0;
	localparam logic [CFGIX_W-1:0] REG_MAX_PAYLOAD      = 1'd1;

	localparam logic ACTION_BYTE  = 1'b0;
	localparam logic ACTION_REARM = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_SIZE  = 3'd1,
		PH_DATA  = 3'd2,
		PH_CS    = 3'd3,
		PH_DONE  = 3'd4,
		PH_ERROR = 3'd5
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] expected_command;
		logic [LEN_W-1:0]  max_payload;
	} cfg_t;

	typedef struct packed {
		logic              data_valid;
		logic [LEN_W-1:0]  data_index;
		logic [BYTE_W-1:0] data_byte;
		logic              frame_done;
		logic              frame_error;
		logic              status;
	} result_t;

endpackage

// ===== src/frc_stream_if.sv =====
// ----------------------------------------------------------------------------
// frc_in_if / frc_out_if
// Valid/ready channels for received words and for result words.
// ----------------------------------------------------------------------------
interface frc_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] rx_byte;

	modport source (output valid, output action, output rx_byte, input ready);
	modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface frc_out_if;
	logic        valid;
	logic        ready;
	logic        data_valid;
	logic [15:0] data_index;
	logic [7:0]  data_byte;
	logic        frame_done;
	logic        frame_error;
	logic        status;

	modport source (output valid, output data_valid, output data_index, output data_byte,
		output frame_done, output frame_error, output status, input ready);
	modport sink   (input valid, input data_valid, input data_index, input data_byte,
		input frame_done, input frame_error, input status, output ready);
endinterface

// ===== src/frc_parser.sv =====
// ----------------------------------------------------------------------------
// frc_parser
// Frame parser state and its single-step update for one received word.
// ----------------------------------------------------------------------------
module frc_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic            action,
	input  logic [7:0]      rx_byte,
	input  frc_pkg::cfg_t   cfg,
	output frc_pkg::result_t result
);
	import frc_pkg::*;

	phase_t            phase_q, phase_d;
	logic [LEN_W-1:0]  byte_count_q, byte_count_d;
	logic [LEN_W-1:0]  frame_length_q, frame_length_d;
	logic [SUM_W-1:0]  running_sum_q, running_sum_d;
	logic [SUM_W-1:0]  received_sum_q, received_sum_d;
	logic [BYTE_W-1:0] val;
	logic [LEN_W-1:0]  new_length;
	logic [SUM_W-1:0]  shifted_sum;
	logic [SUM_W-1:0]  delta;
	logic              err;

	assign val         = rx_byte - OFFSET_CHAR;
	assign new_length  = {frame_length_q[BYTE_W-1:0], val};
	assign shifted_sum = {received_sum_q[SUM_W-BYTE_W-1:0], val};
	assign delta       = {{(SUM_W-BYTE_W-1){1'b0}}, 1'b0, rx_byte}
		- {{(SUM_W-BYTE_W){1'b0}}, OFFSET_CHAR};

	always_comb begin
		phase_d        = phase_q;
		byte_count_d   = byte_count_q;
		frame_length_d = frame_length_q;
		running_sum_d  = running_sum_q;
		received_sum_d = received_sum_q;
		err            = 1'b0;
		if (action == ACTION_REARM) begin
			phase_d        = PH_IDLE;
			byte_count_d   = '0;
			frame_length_d = '0;
			running_sum_d  = '0;
			received_sum_d = '0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (val == cfg.expected_command) begin
						phase_d = PH_SIZE;
					end else begin
						phase_d = PH_ERROR;
						err     = 1'b1;
					end
				end
				PH_SIZE: begin
					if (byte_count_q == '0) begin
						frame_length_d = {{(LEN_W-BYTE_W){1'b0}}, val};
						byte_count_d   = {{(LEN_W-1){1'b0}}, 1'b1};
					end else begin
						frame_length_d = new_length;
						byte_count_d   = '0;
						if (new_length <= cfg.max_payload) begin
							phase_d = PH_DATA;
						end else begin
							phase_d = PH_ERROR;
							err     = 1'b1;
						end
					end
				end
				PH_DATA: begin
					running_sum_d = running_sum_q + delta;
					if (frame_length_q != '0 &&
						byte_count_q < frame_length_q - {{(LEN_W-1){1'b0}}, 1'b1}) begin
						byte_count_d = byte_count_q + {{(LEN_W-1){1'b0}}, 1'b1};
					end else begin
						byte_count_d   = '0;
						received_sum_d = '0;
						phase_d        = PH_CS;
					end
				end
				PH_CS: begin
					received_sum_d = shifted_sum;
					if (byte_count_q < CS_LAST_INDEX) begin
						byte_count_d = byte_count_q + {{(LEN_W-1){1'b0}}, 1'b1};
					end else begin
						byte_count_d = '0;
						if (running_sum_q == shifted_sum) begin
							phase_d = PH_DONE;
						end else begin
							phase_d = PH_ERROR;
							err     = 1'b1;
						end
					end
				end
				PH_DONE: begin
				end
				PH_ERROR: begin
					err = 1'b1;
				end
				default: begin
					phase_d = PH_ERROR;
					err     = 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		result             = '0;
		result.frame_error = (phase_d == PH_ERROR);
		result.status      = err;
		if (action == ACTION_BYTE) begin
			if (phase_q == PH_DATA) begin
				result.data_valid = 1'b1;
				result.data_index = byte_count_q;
				result.data_byte  = rx_byte;
			end
			result.frame_done = (phase_q == PH_CS) && (phase_d == PH_DONE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			byte_count_q   <= '0;
			frame_length_q <= '0;
			running_sum_q  <= '0;
			received_sum_q <= '0;
		end else if (accept) begin
			phase_q        <= phase_d;
			byte_count_q   <= byte_count_d;
			frame_length_q <= frame_length_d;
			running_sum_q  <= running_sum_d;
			received_sum_q <= received_sum_d;
		end
	end

endmodule

// ===== src/frame_receive_checker_top.sv =====
// ----------------------------------------------------------------------------
// frame_receive_checker_top
// Receive-side parser for length-prefixed frames with an additive checksum.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while the result register is empty or
// being drained, and returns exactly one result word for each, registered and
// shown in the cycle after acceptance. The parser computes each result from the
// word and its current state, and the result register captures it at the
// accepting edge; words stream back to back when the sink takes every result.
module frame_receive_checker_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [frc_pkg::CFGIX_W-1:0] cfg_index,
	input  logic [frc_pkg::CFG_W-1:0]   cfg_data,
	frc_in_if.sink                      in_ch,
	frc_out_if.source                   out_ch
);
	import frc_pkg::*;

	cfg_t    cfg_q;
	result_t result;
	result_t result_q;
	logic    out_valid_q;
	logic    accept;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_command <= '0;
			cfg_q.max_payload      <= MAX_PAYLOAD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXPECTED_COMMAND: cfg_q.expected_command <= cfg_data[BYTE_W-1:0];
				REG_MAX_PAYLOAD:      cfg_q.max_payload      <= cfg_data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	frc_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.action  (in_ch.action),
		.rx_byte (in_ch.rx_byte),
		.cfg     (cfg_q),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.data_valid  = result_q.data_valid;
	assign out_ch.data_index  = result_q.data_index;
	assign out_ch.data_byte   = result_q.data_byte;
	assign out_ch.frame_done  = result_q.frame_done;
	assign out_ch.frame_error = result_q.frame_error;
	assign out_ch.status      = result_q.status;

	a_status_implies_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.status |-> result_q.frame_error)
		else $error("status set on a result without the error flag");

	a_done_is_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.frame_done |-> !result_q.frame_error && !result_q.status
			&& !result_q.data_valid)
		else $error("frame done reported together with error or data");

	a_accept_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted word produced no result");

endmodule

// ===== test/tb_frame_receive_checker_top.sv =====
// ----------------------------------------------------------------------------
// tb_frame_receive_checker_top
// Drives received words into the frame receive checker: framed traffic with
// good and bad checksums, wrong commands, oversized lengths, cut-off frames
// and noise, under several register settings. Each word is parsed by a local
// model of the frame parser, and each result word is compared field by field
// with the oldest prediction. Both channels stall in random bursts, except in
// the closing back-to-back phase.
// ----------------------------------------------------------------------------
module tb_frame_receive_checker_top;
	timeunit 1ns;
	timeprecision 1ps;

	import frc_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int MAX_PRINTED = 40;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CFGIX_W-1:0] cfg_index;
	logic [CFG_W-1:0]   cfg_data;

	frc_in_if  in_ch();
	frc_out_if out_ch();

	frame_receive_checker_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	logic [BYTE_W-1:0] cfg_command = '0;
	logic [LEN_W-1:0]  cfg_max_len = MAX_PAYLOAD_RESET;

	phase_t            psr_phase  = PH_IDLE;
	logic [LEN_W-1:0]  psr_count  = '0;
	logic [LEN_W-1:0]  psr_length = '0;
	logic [SUM_W-1:0]  psr_sum    = '0;
	logic [SUM_W-1:0]  psr_cs     = '0;

	result_t     parse_results_q[$];
	bit          idling_enabled = 1'b1;
	int unsigned words_sent     = 0;
	int unsigned results_seen   = 0;
	int          mismatches     = 0;
	int          stuck_cycles   = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic result_t parse_rx_word(input logic act, input logic [BYTE_W-1:0] raw);
		result_t           r;
		logic [BYTE_W-1:0] val;
		r = '0;
		val = raw - OFFSET_CHAR;
		if (act == ACTION_REARM) begin
			psr_phase = PH_IDLE;
			psr_count = '0;
			psr_length = '0;
			psr_sum = '0;
			psr_cs = '0;
		end else begin
			case (psr_phase)
				PH_IDLE: begin
					if (val == cfg_command) begin
						psr_phase = PH_SIZE;
					end else begin
						psr_phase = PH_ERROR;
						r.status = 1'b1;
					end
				end
				PH_SIZE: begin
					if (psr_count == 0) begin
						psr_length = {8'h00, val};
						psr_count = 16'd1;
					end else begin
						psr_length = {psr_length[7:0], val};
						psr_count = '0;
						if (psr_length <= cfg_max_len) begin
							psr_phase = PH_DATA;
						end else begin
							psr_phase = PH_ERROR;
							r.status = 1'b1;
						end
					end
				end
				PH_DATA: begin
					r.data_valid = 1'b1;
					r.data_index = psr_count;
					r.data_byte = raw;
					psr_sum = psr_sum + {56'b0, raw} - {56'b0, OFFSET_CHAR};
					if (psr_length != 0 && psr_count < psr_length - 16'd1) begin
						psr_count = psr_count + 16'd1;
					end else begin
						psr_count = '0;
						psr_cs = '0;
						psr_phase = PH_CS;
					end
				end
				PH_CS: begin
					psr_cs = {psr_cs[SUM_W-9:0], val};
					if (psr_count < CS_LAST_INDEX) begin
						psr_count = psr_count + 16'd1;
					end else begin
						psr_count = '0;
						if (psr_sum == psr_cs) begin
							psr_phase = PH_DONE;
							r.frame_done = 1'b1;
						end else begin
							psr_phase = PH_ERROR;
							r.status = 1'b1;
						end
					end
				end
				PH_DONE: begin
				end
				default: begin
					psr_phase = PH_ERROR;
					r.status = 1'b1;
				end
			endcase
		end
		r.frame_error = (psr_phase == PH_ERROR);
		return r;
	endfunction

	task automatic report_error(input string msg);
		if (mismatches < MAX_PRINTED) begin
			$display("ERROR: %s", msg);
		end
		mismatches++;
	endtask

	task automatic check_field(input string name, input int unsigned n, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want) begin
			report_error($sformatf("result word %0d %s: got %0h, expected %0h", n, name, got,
				want));
		end
	endtask

	always @(posedge clk) begin : word_monitor
		result_t want;
		if (cfg_we === 1'b1) begin
			if (cfg_index == REG_EXPECTED_COMMAND) begin
				cfg_command = cfg_data[BYTE_W-1:0];
			end else if (cfg_index == REG_MAX_PAYLOAD) begin
				cfg_max_len = cfg_data[LEN_W-1:0];
			end
		end
		if (in_ch.valid && in_ch.ready) begin
			parse_results_q.push_back(parse_rx_word(in_ch.action, in_ch.rx_byte));
		end
		if (out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (parse_results_q.size() == 0) begin
				report_error($sformatf("result word %0d arrived with none expected",
					results_seen));
			end else begin
				want = parse_results_q.pop_front();
				check_field("data_valid", results_seen, 16'(out_ch.data_valid),
					16'(want.data_valid));
				check_field("data_index", results_seen, out_ch.data_index, want.data_index);
				check_field("data_byte", results_seen, 16'(out_ch.data_byte),
					16'(want.data_byte));
				check_field("frame_done", results_seen, 16'(out_ch.frame_done),
					16'(want.frame_done));
				check_field("frame_error", results_seen, 16'(out_ch.frame_error),
					16'(want.frame_error));
				check_field("status", results_seen, 16'(out_ch.status), 16'(want.status));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles = stuck_cycles + 1;
		end
		if (stuck_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : result_sink
		int hold;
		hold = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				out_ch.ready <= 1'b0;
			end else if (idling_enabled && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 8) - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_word(input logic act, input logic [BYTE_W-1:0] raw);
		int gap;
		gap = (idling_enabled && $urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			in_ch.action <= 1'($urandom_range(0, 1));
			in_ch.rx_byte <= 8'($urandom);
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.action <= act;
		in_ch.rx_byte <= raw;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		words_sent++;
	endtask

	task automatic wait_for_quiet();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (parse_results_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic apply_config(input logic [BYTE_W-1:0] cmd, input logic [LEN_W-1:0] max_len);
		wait_for_quiet();
		cfg_we <= 1'b1;
		cfg_index <= REG_EXPECTED_COMMAND;
		cfg_data <= {8'($urandom), cmd};
		@(posedge clk);
		cfg_index <= REG_MAX_PAYLOAD;
		cfg_data <= max_len;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_frame(input logic [BYTE_W-1:0] cmd, input logic [LEN_W-1:0] len,
		input int fill, input bit bad_sum, input int cut, input int trailing);
		logic [BYTE_W-1:0] frame_q[$];
		logic [BYTE_W-1:0] raw;
		logic [SUM_W-1:0]  sum;
		int                count;
		sum = '0;
		count = (len == 0) ? 1 : int'(len);
		frame_q.push_back(cmd + OFFSET_CHAR);
		frame_q.push_back(len[15:8] + OFFSET_CHAR);
		frame_q.push_back(len[7:0] + OFFSET_CHAR);
		for (int i = 0; i < count; i++) begin
			raw = (fill < 0) ? 8'($urandom) : 8'(fill);
			sum = sum + {56'b0, raw} - {56'b0, OFFSET_CHAR};
			frame_q.push_back(raw);
		end
		if (bad_sum) begin
			sum = sum ^ (64'd1 << $urandom_range(0, 63));
		end
		for (int i = 7; i >= 0; i--) begin
			frame_q.push_back(sum[i*8 +: 8] + OFFSET_CHAR);
		end
		if (cut < 0 || cut > frame_q.size()) begin
			cut = frame_q.size();
		end
		send_word(ACTION_REARM, 8'($urandom));
		for (int i = 0; i < cut; i++) begin
			send_word(ACTION_BYTE, frame_q[i]);
		end
		repeat (trailing) send_word(ACTION_BYTE, 8'($urandom));
	endtask

	task automatic random_frame();
		int kind;
		int lim;
		kind = $urandom_range(0, 99);
		lim = (cfg_max_len < 12) ? int'(cfg_max_len) : 12;
		if (kind < 3) begin
			lim = (cfg_max_len < 300) ? int'(cfg_max_len) : 300;
			send_frame(cfg_command, 16'($urandom_range(0, lim)), -1, 1'b0, -1,
				$urandom_range(0, 2));
		end else if (kind < 70) begin
			send_frame(cfg_command, 16'($urandom_range(0, lim)), -1,
				$urandom_range(0, 6) == 0, -1, $urandom_range(0, 2));
		end else if (kind < 80) begin
			send_frame(cfg_command + 8'($urandom_range(1, 255)), 16'($urandom_range(0, lim)),
				-1, 1'b0, $urandom_range(1, 4), $urandom_range(0, 2));
		end else if (kind < 88 && cfg_max_len != 16'hFFFF) begin
			send_frame(cfg_command, 16'($urandom_range(int'(cfg_max_len) + 1, 65535)), -1,
				1'b0, $urandom_range(3, 5), 0);
		end else if (kind < 96) begin
			send_frame(cfg_command, 16'($urandom_range(0, lim)), -1, 1'b0,
				$urandom_range(1, lim + 11), 0);
		end else begin
			repeat ($urandom_range(1, 6)) send_word(1'($urandom_range(0, 1)), 8'($urandom));
		end
	endtask

	task automatic run_frames(input int unsigned n);
		int unsigned stop;
		stop = words_sent + n;
		while (words_sent < stop) random_frame();
	endtask

	task automatic test_directed_cases();
		send_frame(8'h00, 16'd0, 8'h00, 1'b0, -1, 1);
		send_frame(8'h00, 16'd0, 8'hFF, 1'b1, -1, 1);
		send_frame(8'h07, 16'd0, -1, 1'b0, 1, 1);
		send_frame(8'h00, 16'd256, -1, 1'b0, 3, 0);
	endtask

	task automatic test_register_extremes();
		apply_config(8'h00, 16'h0000);
		run_frames(100);
		apply_config(8'hFF, 16'hFFFF);
		send_frame(cfg_command, 16'd300, -1, 1'b0, -1, 1);
		run_frames(100);
		apply_config(8'($urandom), 16'($urandom_range(1, 20)));
		run_frames(100);
		apply_config(8'($urandom), 16'($urandom));
		run_frames(100);
	endtask

	task automatic test_random_frames();
		logic [LEN_W-1:0] max_len;
		repeat (4) begin
			case ($urandom_range(0, 2))
				0: max_len = 16'($urandom_range(0, 15));
				1: max_len = 16'($urandom);
				default: max_len = MAX_PAYLOAD_RESET;
			endcase
			apply_config(8'($urandom), max_len);
			run_frames(150);
		end
	endtask

	task automatic test_back_to_back();
		apply_config(8'($urandom), 16'd40);
		idling_enabled = 1'b0;
		run_frames(200);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.action = ACTION_BYTE;
		in_ch.rx_byte = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_register_extremes();
		test_random_frames();
		test_back_to_back();
		wait_for_quiet();
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
